// File: rtl/sccd_pkg.sv
// Shared types and widths for the swept circle collision time pipeline.
`default_nettype none
package sccd_pkg;

   localparam int P_W = 24;
   localparam int V_W = 16;
   localparam int R_W = 16;
   localparam int DP_W = P_W + 1;
   localparam int DV_W = V_W + 1;
   localparam int RS_W = R_W + 1;
   localparam int A_W = 34;
   localparam int B_W = 44;
   localparam int C_W = 51;
   localparam int G_W = 88;
   localparam int H_W = 64;
   localparam int T_W = 17;
   localparam int PC_W = 17;

   typedef enum logic [1:0] {
      STATUS_HIT     = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_OVERLAP = 2'd2
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [A_W-1:0]        a;
      logic signed [H_W-1:0] h;
      logic signed [G_W-1:0] g;
      logic [T_W-1:0]        t;
   } srch_type;

endpackage
`default_nettype wire

// File: rtl/sccd_step.sv
// One bit of the root search: tries setting time bit K, updates f(t) and its slope.
`default_nettype none
module sccd_step
   import sccd_pkg::*;
#(
   parameter int K = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire srch_type in_st,
   output logic          out_valid,
   output srch_type      out_st
);

   localparam logic CAPPED = (K < T_W - 1);

   logic                  valid_ff;
   srch_type              st_ff;
   srch_type              st_in;
   logic signed [G_W-1:0] g_n;
   logic signed [H_W-1:0] h_n;
   logic                  ok;

   always_comb begin
      g_n = in_st.g + (G_W'(in_st.h) <<< K) + $signed(G_W'(in_st.a) << (2 * K));
      h_n = in_st.h + $signed(H_W'(in_st.a) << (K + 1));
      ok  = (h_n[H_W-1] || (h_n == '0)) && !g_n[G_W-1]
            && !(CAPPED && in_st.t[T_W-1]);
      st_in = in_st;
      if (ok) begin
         st_in.g = g_n;
         st_in.h = h_n;
         st_in.t = in_st.t | (T_W'(1) << K);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;

endmodule
`default_nettype wire

// File: rtl/swept_circle_collision_time.sv
// Top level: time of first contact of two circles moving over one step.
// Usage: one pair of circles per req beat (centers Q16.8, movement per step
// and radii Q8.8); one rsp beat per req beat, in order, with a status
// (hit, no collision, overlapping at start) and the hit time in Q1.16,
// saturating at 1.0 and zero unless the status is hit.
// Six setup stages (differences, products, quadratic coefficients, partial
// products of the discriminant, their sums, the decision) are followed by
// 17 search stages that each settle one bit of the time by stepping f(t)
// with shifts and adds.
// Throughput is one beat per cycle while the pipeline advances; every stage holds one beat.
// Reset (synchronous, active high) empties the pipeline.
// While rsp_stall is high and a result waits, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
`default_nettype none
module swept_circle_collision_time
   import sccd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [P_W-1:0] req_first_x,
   input  wire logic signed [P_W-1:0] req_first_y,
   input  wire logic signed [V_W-1:0] req_first_vel_x,
   input  wire logic signed [V_W-1:0] req_first_vel_y,
   input  wire logic [R_W-1:0]        req_first_radius,
   input  wire logic signed [P_W-1:0] req_second_x,
   input  wire logic signed [P_W-1:0] req_second_y,
   input  wire logic signed [V_W-1:0] req_second_vel_x,
   input  wire logic signed [V_W-1:0] req_second_vel_y,
   input  wire logic [R_W-1:0]        req_second_radius,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [T_W-1:0]             rsp_hit_time
);

   logic adv;
   logic [6:1] v_ff;

   // stage 1
   logic signed [DP_W-1:0] dpx_ff, dpy_ff;
   logic signed [DV_W-1:0] dvx_ff, dvy_ff;
   logic [RS_W-1:0]        rs_ff;
   // stage 2
   logic signed [2*DP_W-1:0]   pxx_ff, pyy_ff;
   logic signed [DP_W+DV_W-1:0] pxvx_ff, pyvy_ff;
   logic signed [2*DV_W-1:0]   vxx_ff, vyy_ff;
   logic [2*RS_W-1:0]          rr_ff;
   // stage 3
   logic [A_W-1:0]        a_in, a3_ff;
   logic signed [B_W-1:0] b3_ff;
   logic signed [C_W-1:0] c3_ff;
   // stage 4
   logic [A_W-1:0]        a4_ff;
   logic signed [B_W-1:0] b4_ff;
   logic signed [C_W-1:0] c4_ff;
   logic                  le1_ff4, le2_ff4;
   logic [B_W-1:0]        bmag;
   logic [C_W-1:0]        cu;
   logic [B_W-1:0]        bhh_ff, bhl_ff, bll_ff;
   logic [2*PC_W-1:0]     ac_ff [2][3];
   logic signed [B_W+1:0] nb_s, a2_s;
   logic signed [C_W+1:0] sum3;
   // stage 5
   logic [A_W-1:0]        a5_ff;
   logic signed [B_W-1:0] b5_ff;
   logic signed [C_W-1:0] c5_ff;
   logic                  le1_ff5, le2_ff5;
   logic [G_W-1:0]        bsq_in, fac_in, bsq_ff, fac_ff;
   // stage 6
   srch_type              s6_in, s6_ff;
   logic                  hit;

   srch_type sr_st [18];
   logic     sr_v  [18];

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:1], req_valid};
      end
   end

   always_comb begin
      a_in = A_W'(vxx_ff) + A_W'(vyy_ff);
      if (a_in == '0) begin
         a_in = A_W'(65536);
      end
      bmag = b3_ff[B_W-1] ? B_W'(-b3_ff) : B_W'(b3_ff);
      cu   = c3_ff[C_W-1] ? '0 : C_W'(c3_ff);
      nb_s = -(B_W+2)'(b3_ff);
      a2_s = $signed({{(B_W+1-A_W){1'b0}}, a3_ff, 1'b0});
      sum3 = $signed({{(C_W+2-A_W){1'b0}}, a3_ff}) + (C_W+2)'(b3_ff) + (C_W+2)'(c3_ff);
   end

   always_comb begin
      bsq_in = (G_W'(bhh_ff) << 44) + (G_W'(bhl_ff) << 23) + G_W'(bll_ff);
      fac_in = '0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 3; j++) begin
            fac_in = fac_in + (G_W'(ac_ff[i][j]) << (PC_W * (i + j) + 2));
         end
      end
   end

   always_comb begin
      hit = !c5_ff[C_W-1] && (b5_ff[B_W-1] || (b5_ff == '0)) && (bsq_ff >= fac_ff)
            && (le1_ff5 || le2_ff5);
      s6_in.status = c5_ff[C_W-1] ? STATUS_OVERLAP : (hit ? STATUS_HIT : STATUS_MISS);
      s6_in.a      = a5_ff;
      s6_in.h      = H_W'(b5_ff) <<< 16;
      s6_in.g      = G_W'(c5_ff) <<< 32;
      s6_in.t      = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dpx_ff  <= DP_W'(req_second_x) - DP_W'(req_first_x);
         dpy_ff  <= DP_W'(req_second_y) - DP_W'(req_first_y);
         dvx_ff  <= DV_W'(req_second_vel_x) - DV_W'(req_first_vel_x);
         dvy_ff  <= DV_W'(req_second_vel_y) - DV_W'(req_first_vel_y);
         rs_ff   <= RS_W'(req_first_radius) + RS_W'(req_second_radius);

         pxx_ff  <= dpx_ff * dpx_ff;
         pyy_ff  <= dpy_ff * dpy_ff;
         pxvx_ff <= (DP_W+DV_W)'(dpx_ff) * (DP_W+DV_W)'(dvx_ff);
         pyvy_ff <= (DP_W+DV_W)'(dpy_ff) * (DP_W+DV_W)'(dvy_ff);
         vxx_ff  <= dvx_ff * dvx_ff;
         vyy_ff  <= dvy_ff * dvy_ff;
         rr_ff   <= rs_ff * rs_ff;

         a3_ff   <= a_in;
         b3_ff   <= (B_W'(pxvx_ff) + B_W'(pyvy_ff)) <<< 1;
         c3_ff   <= C_W'(pxx_ff) + C_W'(pyy_ff) - $signed(C_W'(rr_ff));

         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         c4_ff   <= c3_ff;
         le1_ff4 <= nb_s <= a2_s;
         le2_ff4 <= sum3[C_W+1] || (sum3 == '0);
         bhh_ff  <= B_W'(bmag[B_W-1:22]) * B_W'(bmag[B_W-1:22]);
         bhl_ff  <= B_W'(bmag[B_W-1:22]) * B_W'(bmag[21:0]);
         bll_ff  <= B_W'(bmag[21:0]) * B_W'(bmag[21:0]);
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
               ac_ff[i][j] <= (2*PC_W)'(a3_ff[PC_W*i +: PC_W]) * (2*PC_W)'(cu[PC_W*j +: PC_W]);
            end
         end

         a5_ff   <= a4_ff;
         b5_ff   <= b4_ff;
         c5_ff   <= c4_ff;
         le1_ff5 <= le1_ff4;
         le2_ff5 <= le2_ff4;
         bsq_ff  <= bsq_in;
         fac_ff  <= fac_in;

         s6_ff   <= s6_in;
      end
   end

   assign sr_st[0] = s6_ff;
   assign sr_v[0]  = v_ff[6];

   for (genvar i = 0; i < T_W; i++) begin : g_srch
      sccd_step #(.K(T_W - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (sr_v[i]),
         .in_st    (sr_st[i]),
         .out_valid(sr_v[i+1]),
         .out_st   (sr_st[i+1])
      );
   end

   assign rsp_valid    = sr_v[T_W];
   assign rsp_status   = sr_st[T_W].status;
   assign rsp_hit_time = (sr_st[T_W].status == STATUS_HIT) ? sr_st[T_W].t : '0;

endmodule
`default_nettype wire

// File: rtl/sccd_chk.sv
// Port-level checks for the swept circle collision time block, bound to the top level.
`default_nettype none
module sccd_chk
   import sccd_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_stall,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input wire logic [1:0]     rsp_status,
   input wire logic [T_W-1:0] rsp_hit_time
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_time) && $stable(rsp_status))
      else $error("stalled rsp beat changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_HIT || rsp_status == STATUS_MISS
                    || rsp_status == STATUS_OVERLAP)
      else $error("bad status");

   a_time0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_HIT |-> rsp_hit_time == '0)
      else $error("hit time set without hit");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_time <= T_W'(65536))
      else $error("hit time above 1.0");

   a_bp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

endmodule

bind swept_circle_collision_time sccd_chk u_sccd_chk (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_hit_time(rsp_hit_time)
);
`default_nettype wire
